FILE: src/pwts_pkg.sv
`timescale 1ns / 1ps
package pwts_pkg;

    localparam int NUM_COEFS = 12;
    localparam int Q_BITS    = 31;

    typedef enum logic
    {
        REQ_LOAD    = 1'b0,
        REQ_PROJECT = 1'b1
    } req_type_t;

    typedef enum logic [1:0]
    {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_HALF_W   = 2'd2,
        CFG_HALF_H   = 2'd3
    } cfg_index_t;

    typedef struct packed
    {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] half_w;
        logic signed [31:0] half_h;
    } vp_cfg_t;

    typedef struct packed
    {
        logic        is_load;
        logic [3:0]  idx;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } q_entry_t;

endpackage

FILE: src/perspective_world_to_screen.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle unless the output stalls; the 31-stage quotient pipeline makes up most of the latency
// load beats produce no result; the whole pipeline stalls while a result waits
// reset clears the queue and pipeline valids and sets the viewport registers;
// matrix coefficients are undefined until loaded
module perspective_world_to_screen
    import pwts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [3:0]  coef_index,
    input  logic [31:0] coef_value,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] screen_x,
    output logic [31:0] screen_y,
    output logic        visible,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    vp_cfg_t  cfg_reg;
    logic     q_valid;
    logic     q_ready;
    q_entry_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= 32'sd0;
            cfg_reg.origin_y <= 32'sd0;
            cfg_reg.half_w   <= 32'sd62914560;
            cfg_reg.half_h   <= 32'sd35389440;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ORIGIN_X: cfg_reg.origin_x <= cfg_data;
                CFG_ORIGIN_Y: cfg_reg.origin_y <= cfg_data;
                CFG_HALF_W:   cfg_reg.half_w   <= cfg_data;
                CFG_HALF_H:   cfg_reg.half_h   <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    pwts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data)
    );

    pwts_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .visible   (visible)
    );

endmodule

FILE: src/pwts_front.sv
`timescale 1ns / 1ps
module pwts_front
    import pwts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [3:0]  coef_index,
    input  logic [31:0] coef_value,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_z,
    output logic        q_valid,
    input  logic        q_ready,
    output q_entry_t    q_data
);

    q_entry_t   mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    logic       keep;
    q_entry_t   entry;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];

    // out-of-range loads are dropped here
    assign keep = (req_type == REQ_PROJECT) || (coef_index < 4'(NUM_COEFS));
    assign push = in_valid && in_ready && keep;
    assign pop  = q_valid && q_ready;

    always_comb
    begin
        entry.is_load = (req_type == REQ_LOAD);
        entry.idx     = coef_index;
        entry.a       = (req_type == REQ_LOAD) ? coef_value : point_x;
        entry.b       = point_y;
        entry.c       = point_z;
        count_next    = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/pwts_back.sv
`timescale 1ns / 1ps
module pwts_back
    import pwts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  q_entry_t    q_data,
    input  vp_cfg_t     cfg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] screen_x,
    output logic [31:0] screen_y,
    output logic        visible
);

    localparam int PW   = 64 - FRAC_BITS;
    localparam int SUMW = PW + 2;
    localparam int DW   = SUMW + Q_BITS;
    localparam int NDS  = Q_BITS;
    localparam logic signed [SUMW-1:0] W_MIN =
        SUMW'((((64'd1) << FRAC_BITS) + 64'd500) / 64'd1000);

    logic        en;
    logic        take;
    logic [31:0] coef_reg [0:NUM_COEFS-1];

    // products
    logic               vp_reg;
    logic signed [63:0] prod_reg [0:8];
    logic signed [63:0] prod_next [0:8];
    logic [31:0]        tr_reg [0:2];

    // clip sums
    logic                 vs_reg;
    logic signed [SUMW-1:0] sum_reg [0:2];
    logic signed [SUMW-1:0] sum_next [0:2];

    // division lanes, index 0 is x and 1 is y
    logic [NDS:0]      dv_reg;
    logic [NDS:0]      dvis_reg;
    logic [SUMW-1:0]   dw_reg [0:NDS];
    logic [DW-1:0]     r_reg [0:1][0:NDS];
    logic [Q_BITS-1:0] qt_reg [0:1][0:NDS];
    logic              neg_reg [0:1][0:NDS];
    logic              ov_reg [0:1][0:NDS];
    logic [DW-1:0]     r_next [0:1][0:NDS-1];
    logic              bit_next [0:1][0:NDS-1];
    logic [SUMW-1:0]   mag [0:1];
    logic [DW-1:0]     ov_lim;
    logic              vis0;

    logic               vn_reg;
    logic               nvis_reg;
    logic signed [31:0] n_reg [0:1];
    logic signed [31:0] n_next [0:1];

    logic               vm_reg;
    logic               mvis_reg;
    logic signed [63:0] m_reg [0:1];

    logic               out_valid_reg;
    logic [31:0]        sx_reg;
    logic [31:0]        sy_reg;
    logic               vis_reg;
    logic signed [SUMW-1:0] sx_sum;
    logic signed [SUMW-1:0] sy_sum;
    logic [31:0]        sx_sat;
    logic [31:0]        sy_sat;

    function automatic logic [31:0] sat32(input logic signed [SUMW-1:0] v);
        logic [31:0] r;
        if (v > SUMW'(64'sh7FFFFFFF))
        begin
            r = 32'h7FFFFFFF;
        end
        else if (v < -SUMW'(64'sh80000000))
        begin
            r = 32'h80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign en        = !out_valid_reg || out_ready;
    assign q_ready   = en;
    assign take      = q_valid && en;
    assign out_valid = out_valid_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign visible   = vis_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r*3+c] = $signed(coef_reg[r*3+c]) *
                    $signed((r == 0) ? q_data.a : ((r == 1) ? q_data.b : q_data.c));
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = SUMW'(prod_reg[c] >>> FRAC_BITS)
                        + SUMW'(prod_reg[3+c] >>> FRAC_BITS)
                        + SUMW'(prod_reg[6+c] >>> FRAC_BITS)
                        + SUMW'($signed(tr_reg[c]));
        end
    end

    always_comb
    begin
        vis0 = (sum_reg[2] > '0) && (sum_reg[2] >= W_MIN) &&
               (cfg.half_w > 0) && (cfg.half_h > 0);
        ov_lim = DW'(sum_reg[2]) << (Q_BITS - FRAC_BITS);
        for (int l = 0; l < 2; l++)
        begin
            mag[l] = sum_reg[l][SUMW-1] ? SUMW'(-sum_reg[l]) : sum_reg[l];
        end
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k < NDS; k++)
            begin
                bit_next[l][k] = r_reg[l][k] >= (DW'(dw_reg[k]) << (Q_BITS - 1 - k));
                r_next[l][k]   = bit_next[l][k]
                               ? r_reg[l][k] - (DW'(dw_reg[k]) << (Q_BITS - 1 - k))
                               : r_reg[l][k];
            end
            if (ov_reg[l][NDS])
            begin
                n_next[l] = neg_reg[l][NDS] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                n_next[l] = neg_reg[l][NDS] ? -$signed({1'b0, qt_reg[l][NDS]})
                                            : $signed({1'b0, qt_reg[l][NDS]});
            end
        end
        sx_sum = SUMW'(cfg.origin_x) + SUMW'(m_reg[0] >>> FRAC_BITS) + SUMW'(cfg.half_w);
        sy_sum = SUMW'(cfg.origin_y) - SUMW'(m_reg[1] >>> FRAC_BITS) + SUMW'(cfg.half_h);
        sx_sat = sat32(sx_sum);
        sy_sat = sat32(sy_sum);
    end

    always_ff @(posedge clk)
    begin
        if (take && q_data.is_load)
        begin
            coef_reg[q_data.idx] <= q_data.a;
        end
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            for (int c = 0; c < 3; c++)
            begin
                tr_reg[c]  <= coef_reg[9+c];
                sum_reg[c] <= sum_next[c];
            end
            dw_reg[0] <= sum_reg[2];
            dvis_reg[0] <= vis0;
            for (int l = 0; l < 2; l++)
            begin
                r_reg[l][0]   <= DW'(mag[l]) << FRAC_BITS;
                qt_reg[l][0]  <= '0;
                neg_reg[l][0] <= sum_reg[l][SUMW-1];
                ov_reg[l][0]  <= DW'(mag[l]) >= ov_lim;
                for (int k = 0; k < NDS; k++)
                begin
                    r_reg[l][k+1]   <= r_next[l][k];
                    qt_reg[l][k+1]  <= {qt_reg[l][k][Q_BITS-2:0], bit_next[l][k]};
                    neg_reg[l][k+1] <= neg_reg[l][k];
                    ov_reg[l][k+1]  <= ov_reg[l][k];
                end
                n_reg[l] <= n_next[l];
            end
            for (int k = 0; k < NDS; k++)
            begin
                dw_reg[k+1]   <= dw_reg[k];
                dvis_reg[k+1] <= dvis_reg[k];
            end
            nvis_reg <= dvis_reg[NDS];
            m_reg[0] <= cfg.half_w * n_reg[0];
            m_reg[1] <= cfg.half_h * n_reg[1];
            mvis_reg <= nvis_reg;
            vis_reg  <= mvis_reg;
            sx_reg   <= mvis_reg ? sx_sat : 32'd0;
            sy_reg   <= mvis_reg ? sy_sat : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg        <= 1'b0;
            vs_reg        <= 1'b0;
            dv_reg        <= '0;
            vn_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg        <= take && !q_data.is_load;
            vs_reg        <= vp_reg;
            dv_reg        <= {dv_reg[NDS-1:0], vs_reg};
            vn_reg        <= dv_reg[NDS];
            vm_reg        <= vn_reg;
            out_valid_reg <= vm_reg;
        end
    end

endmodule
